>>> hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

   // Width of the accumulated message length (kept modulo 2^LEN_BITS)
   localparam int LEN_BITS = 32;

   localparam int BYTE_BITS  = 8;
   localparam int LIMIT_BITS = 9;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd256;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_LENGTH  = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_EMPTY    = 2'd1,
      KIND_BADCOUNT = 2'd2,
      KIND_ABORT    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [BYTE_BITS-1:0] payload_byte;
      logic                 last;
   } result_type;

endpackage

>>> hw/rtl/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Header/length/payload state machine; produces at most one result per byte.
// ----------------------------------------------------------------------------
module lpd_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [lpd_pkg::BYTE_BITS-1:0]       rx_byte,
   input  logic                                abort,
   input  logic                                csr_wr_en,
   input  logic [lpd_pkg::LIMIT_BITS-1:0]      csr_wr_data,
   output logic                                push,
   output lpd_pkg::result_type                 push_data
);

   lpd_pkg::phase_type                    phase_ff, phase_in;
   logic [lpd_pkg::BYTE_BITS-1:0]         header_left_ff, header_left_in;
   logic [lpd_pkg::LEN_BITS-1:0]          msg_len_ff, msg_len_in;
   logic [lpd_pkg::LIMIT_BITS-1:0]        count_limit_ff;

   logic [lpd_pkg::LEN_BITS+lpd_pkg::BYTE_BITS-1:0] len_shift;
   logic [lpd_pkg::LEN_BITS-1:0]          len_acc;
   logic [lpd_pkg::LEN_BITS-1:0]          len_dec;
   logic [lpd_pkg::BYTE_BITS-1:0]         left_dec;
   logic                                  has_result;

   assign len_shift = {msg_len_ff, rx_byte};
   assign len_acc   = len_shift[lpd_pkg::LEN_BITS-1:0];
   assign len_dec   = msg_len_ff - {{(lpd_pkg::LEN_BITS-1){1'b0}}, 1'b1};
   assign left_dec  = header_left_ff - 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      header_left_in = header_left_ff;
      msg_len_in     = msg_len_ff;
      has_result     = 1'b0;
      push_data      = '{kind: lpd_pkg::KIND_PAYLOAD, payload_byte: '0, last: 1'b0};

      if (abort) begin
         phase_in       = lpd_pkg::PH_HEADER;
         header_left_in = '0;
         msg_len_in     = '0;
         has_result     = 1'b1;
         push_data.kind = lpd_pkg::KIND_ABORT;
      end else begin
         unique case (phase_ff)
            lpd_pkg::PH_LENGTH: begin
               msg_len_in     = len_acc;
               header_left_in = left_dec;
               if (left_dec == '0) begin
                  if (len_acc == '0) begin
                     phase_in       = lpd_pkg::PH_HEADER;
                     msg_len_in     = '0;
                     has_result     = 1'b1;
                     push_data.kind = lpd_pkg::KIND_EMPTY;
                  end else begin
                     phase_in = lpd_pkg::PH_PAYLOAD;
                  end
               end
            end
            lpd_pkg::PH_PAYLOAD: begin
               msg_len_in             = len_dec;
               has_result             = 1'b1;
               push_data.payload_byte = rx_byte;
               if (len_dec == '0) begin
                  phase_in       = lpd_pkg::PH_HEADER;
                  header_left_in = '0;
                  push_data.last = 1'b1;
               end
            end
            default: begin
               // header wait; also recovers from an illegal phase code
               header_left_in = '0;
               msg_len_in     = '0;
               phase_in       = lpd_pkg::PH_HEADER;
               if ({1'b0, rx_byte} >= count_limit_ff) begin
                  has_result     = 1'b1;
                  push_data.kind = lpd_pkg::KIND_BADCOUNT;
               end else if (rx_byte == '0) begin
                  has_result     = 1'b1;
                  push_data.kind = lpd_pkg::KIND_EMPTY;
               end else begin
                  phase_in       = lpd_pkg::PH_LENGTH;
                  header_left_in = rx_byte;
               end
            end
         endcase
      end
   end

   assign push = accept & has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= lpd_pkg::PH_HEADER;
         header_left_ff <= '0;
         msg_len_ff     <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         header_left_ff <= header_left_in;
         msg_len_ff     <= msg_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_limit_ff <= lpd_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         count_limit_ff <= csr_wr_data;
      end
   end

   // An accepted abort always lands back in header wait
   assert property (@(posedge clock) disable iff (reset)
      accept && abort |=> phase_ff == lpd_pkg::PH_HEADER)
      else $error("abort did not return to header wait");

   // Payload phase never holds a zero remaining count
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == lpd_pkg::PH_PAYLOAD |-> msg_len_ff != '0)
      else $error("payload phase with zero bytes left");

   // Length phase always has length bytes outstanding
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == lpd_pkg::PH_LENGTH |-> header_left_ff != '0)
      else $error("length phase with no length bytes left");

endmodule

>>> hw/rtl/lpd_out_buf.sv
// ----------------------------------------------------------------------------
// lpd_out_buf
// Result register with a skid stage; decouples input ready from rsp_ready.
// ----------------------------------------------------------------------------
module lpd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lpd_pkg::result_type  push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lpd_pkg::result_type  out_data
);

   logic                out_valid_ff;
   logic                skid_valid_ff;
   lpd_pkg::result_type out_data_ff;
   lpd_pkg::result_type skid_data_ff;
   logic                pop;

   assign pop       = out_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (push && (pop || !out_valid_ff)) begin
         out_data_ff <= push_data;
      end
      if (push && out_valid_ff && !pop) begin
         skid_data_ff <= push_data;
      end
   end

   // Skid entry only exists behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds data while output register is empty");

   // A held skid entry moves forward on the next pop
   assert property (@(posedge clock) disable iff (reset)
      pop && skid_valid_ff |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not advanced");

   // last only ever accompanies a payload byte
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.last |-> out_data_ff.kind == lpd_pkg::KIND_PAYLOAD)
      else $error("last set on a non-payload result");

endmodule

>>> hw/rtl/length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer
// Splits a byte stream of count/length/payload framed messages.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock while req_ready is high. Each message is
// a count byte, that many big-endian length bytes, then the payload; every
// payload byte comes out with rsp_last on the final one, a zero length
// gives an empty-message result, a count byte at or above csr_wr_data's
// last written limit (reset 256) gives an error result, and req_abort
// drops the message in progress and reports it. Each byte is parsed
// combinationally and its result is registered; a result register plus
// one skid entry keep req_ready high until two results are waiting, so
// the sustained rate is one byte per clock whenever rsp_ready is high.
module length_prefix_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lpd_pkg::BYTE_BITS-1:0]      req_rx_byte,
   input  logic                               req_abort,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_kind,
   output logic [lpd_pkg::BYTE_BITS-1:0]      rsp_payload_byte,
   output logic                               rsp_last,
   input  logic                               csr_wr_en,
   input  logic [lpd_pkg::LIMIT_BITS-1:0]     csr_wr_data
);

   logic                accept;
   logic                push;
   logic                space;
   lpd_pkg::result_type push_data;
   lpd_pkg::result_type out_data;

   assign req_ready = space;
   assign accept    = req_valid & space;

   lpd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .abort       (req_abort),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data)
   );

   lpd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_last         = out_data.last;

endmodule

>>> sim/lpd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_frame_checker
// Result checker for the length-prefix deframer.
// ----------------------------------------------------------------------------
// Watches the request, result and register ports at each rising edge. Runs
// its own copy of the message parser on every accepted request, queues the
// result that the request should cause, and compares each accepted result
// field by field with the oldest queued one. Hands back the number of
// failures and the number of results still owed by the block.
module lpd_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [lpd_pkg::BYTE_BITS-1:0]  req_rx_byte,
   input  logic                          req_abort,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_kind,
   input  logic [lpd_pkg::BYTE_BITS-1:0]  rsp_payload_byte,
   input  logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [lpd_pkg::LIMIT_BITS-1:0] csr_wr_data,
   output int                            errors,
   output int                            results_pending
);

   lpd_pkg::phase_type               parse_phase;
   logic [lpd_pkg::BYTE_BITS-1:0]    header_left;
   logic [lpd_pkg::LEN_BITS-1:0]     length_left;
   logic [lpd_pkg::LIMIT_BITS-1:0]   count_limit;
   lpd_pkg::result_type              results_due[$];
   bit                               produced;
   lpd_pkg::result_type              predicted;
   lpd_pkg::result_type              oldest;

   task automatic clear_message();
      parse_phase = lpd_pkg::PH_HEADER;
      header_left = '0;
      length_left = '0;
   endtask

   // Parse one stream byte; has_result tells whether a result comes out.
   task automatic deframe_step(input logic [lpd_pkg::BYTE_BITS-1:0] rx,
                               input logic drop,
                               output bit has_result,
                               output lpd_pkg::result_type res);
      has_result       = 1'b1;
      res.kind         = lpd_pkg::KIND_PAYLOAD;
      res.payload_byte = '0;
      res.last         = 1'b0;
      if (drop) begin
         clear_message();
         res.kind = lpd_pkg::KIND_ABORT;
      end else begin
         case (parse_phase)
            lpd_pkg::PH_LENGTH: begin
               // shift in big-endian, upper bytes fall off the top
               length_left = {length_left[lpd_pkg::LEN_BITS-lpd_pkg::BYTE_BITS-1:0], rx};
               header_left = header_left - 1'b1;
               if (header_left != 0) begin
                  has_result = 1'b0;
               end else if (length_left == 0) begin
                  clear_message();
                  res.kind = lpd_pkg::KIND_EMPTY;
               end else begin
                  parse_phase = lpd_pkg::PH_PAYLOAD;
                  has_result  = 1'b0;
               end
            end
            lpd_pkg::PH_PAYLOAD: begin
               length_left      = length_left - 1'b1;
               res.payload_byte = rx;
               if (length_left == 0) begin
                  clear_message();
                  res.last = 1'b1;
               end
            end
            default: begin
               if ({1'b0, rx} >= count_limit) begin
                  clear_message();
                  res.kind = lpd_pkg::KIND_BADCOUNT;
               end else if (rx == 0) begin
                  clear_message();
                  res.kind = lpd_pkg::KIND_EMPTY;
               end else begin
                  parse_phase = lpd_pkg::PH_LENGTH;
                  header_left = rx;
                  length_left = '0;
                  has_result  = 1'b0;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         count_limit = lpd_pkg::LIMIT_RESET;
         results_due.delete();
         errors = 0;
      end else begin
         if (csr_wr_en) begin
            count_limit = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               errors++;
               $display("%0t: result with none expected: kind %0d byte %02h last %0b",
                        $time, rsp_kind, rsp_payload_byte, rsp_last);
            end else begin
               oldest = results_due.pop_front();
               if (rsp_kind !== oldest.kind) begin
                  errors++;
                  $display("%0t: kind expected %0d, actual %0d",
                           $time, oldest.kind, rsp_kind);
               end
               if (rsp_payload_byte !== oldest.payload_byte) begin
                  errors++;
                  $display("%0t: payload_byte expected %02h, actual %02h",
                           $time, oldest.payload_byte, rsp_payload_byte);
               end
               if (rsp_last !== oldest.last) begin
                  errors++;
                  $display("%0t: last expected %0b, actual %0b",
                           $time, oldest.last, rsp_last);
               end
            end
         end
         // queue after the compare: a request never yields its result at its own edge
         if (req_valid && req_ready) begin
            deframe_step(req_rx_byte, req_abort, produced, predicted);
            if (produced) begin
               results_due.push_back(predicted);
            end
         end
      end
      results_pending = results_due.size();
   end

endmodule

>>> sim/tb_length_prefix_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer
// Stimulus and verdict for the length-prefix deframer.
// ----------------------------------------------------------------------------
// Drives a short directed set of frames (empty, zero length, short payloads,
// rejected counts, aborts), then phases of random framed messages under a
// range of count limits, mixed with broken frames and stray bytes. Both
// sides idle at random; once the result side holds off long enough to back
// up the block. The checker instance does all prediction and comparison.
module tb_length_prefix_deframer;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 115;
   localparam int DIRECTED     = 23;
   localparam int LEN_WINDOW   = lpd_pkg::LEN_BITS / lpd_pkg::BYTE_BITS;
   localparam int HOLD_CYCLES  = 300;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [lpd_pkg::BYTE_BITS-1:0]  req_rx_byte;
   logic                           req_abort;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [1:0]                     rsp_kind;
   logic [lpd_pkg::BYTE_BITS-1:0]  rsp_payload_byte;
   logic                           rsp_last;
   logic                           csr_wr_en;
   logic [lpd_pkg::LIMIT_BITS-1:0] csr_wr_data;

   int          errors;
   int          results_pending;
   int          cycle_count;
   int          items_sent;
   int unsigned limit_now;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          hold_results;

   length_prefix_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_abort        (req_abort),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   lpd_frame_checker frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_abort        (req_abort),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .errors           (errors),
      .results_pending  (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input logic [lpd_pkg::BYTE_BITS-1:0] rx, input logic drop);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      req_abort   <= drop;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait for every owed result.
   task automatic drain();
      req_valid <= 1'b0;
      wait (results_pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_limit(input int unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[lpd_pkg::LIMIT_BITS-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
   endtask

   // Stray bytes with random aborts, then an abort to get back to header wait.
   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_message(input bit long_msg);
      int unsigned roll;
      int unsigned top_count;
      int unsigned cnt;
      int unsigned len;
      int unsigned cut_at;
      int          i;
      bit          broken;
      roll      = $urandom_range(0, 99);
      top_count = (limit_now == 0) ? 0 : (limit_now > 256) ? 255 : limit_now - 1;
      if (long_msg) begin
         cnt = 2;
      end else if (limit_now == 0) begin
         cnt = $urandom_range(0, 255);
      end else if (roll < 6 && limit_now <= 255) begin
         cnt = $urandom_range(limit_now, 255);
      end else if (roll < 12 || top_count == 0) begin
         cnt = 0;
      end else if (roll < 14) begin
         cnt = $urandom_range(1, top_count);
      end else begin
         cnt = $urandom_range(1, (top_count < LEN_WINDOW) ? top_count : LEN_WINDOW);
      end
      send_item(cnt[lpd_pkg::BYTE_BITS-1:0], 1'b0);
      if (cnt == 0 || cnt >= limit_now) begin
         return;
      end

      roll = $urandom_range(0, 99);
      if (long_msg) begin
         len = 60;
      end else if (roll < 25) begin
         len = 0;
      end else if (roll < 30) begin
         len = $urandom_range(13, 40);
      end else begin
         len = $urandom_range(1, 12);
      end
      broken = !long_msg && ($urandom_range(0, 19) == 0);

      // bytes above the length window shift out, so they carry junk
      for (i = cnt; i > 0; i--) begin
         if (broken || i > LEN_WINDOW) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_item(8'(len >> (8 * (i - 1))), 1'b0);
         end
      end

      if (broken) begin
         repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else if (len != 0) begin
         cut_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len - 1) : len;
         for (i = 0; i < cut_at; i++) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end
         if (cut_at < len) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Result side: random stalls, and one long hold-off when asked.
   initial begin
      int unsigned stall;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = rsp_idle_on ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned limits [8];
      int          p;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      req_abort    = 1'b0;
      rsp_ready    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      items_sent   = 0;
      limit_now    = lpd_pkg::LIMIT_RESET;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      hold_results = 1'b0;
      limits = '{256, 5, 511, 1, 0, 0, 300, 2};
      limits[5] = $urandom_range(2, 256);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // abort with nothing in progress, then a zero count
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b0);
      // one length byte of zero
      send_item(8'h01, 1'b0);
      send_item(8'h00, 1'b0);
      // two-byte length, payload at both byte extremes
      send_item(8'h02, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h02, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hA5, 1'b0);
      // drop a message in the middle of its payload
      send_item(8'h03, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h05, 1'b0);
      send_item(8'h5A, 1'b0);
      send_item(8'h3C, 1'b0);
      send_item(8'h00, 1'b1);
      // tight limits: only a zero count passes, then nothing does
      set_limit(1);
      send_item(8'h00, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hFF, 1'b0);
      set_limit(0);
      send_item(8'h00, 1'b0);

      for (p = 0; p < 8; p++) begin
         set_limit(limits[p]);
         req_idle_on = (p % 3) != 1;
         rsp_idle_on = (p % 4) != 2;
         if (p == 0) begin
            // back up the block with a full-rate message while results stall
            req_idle_on  = 1'b0;
            hold_results = 1'b1;
            send_message(1'b1);
            req_idle_on  = 1'b1;
            drain();
         end
         while (items_sent < DIRECTED + (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 8) begin
               send_noise();
            end else begin
               send_message(1'b0);
            end
         end
      end

      drain();
      repeat (10) @(negedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
